// ----- sv/hill_cipher_block_transform_top_macros.svh -----
// Assertion macros for the checker of the Hill cipher block transform.
`ifndef HILL_CIPHER_BLOCK_TRANSFORM_TOP_MACROS_SVH
`define HILL_CIPHER_BLOCK_TRANSFORM_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define HCBT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbt assertion failed");

// Antecedent implies consequent in the next cycle.
`define HCBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbt assertion failed");

`endif

// ----- sv/hcbt_pkg.sv -----
// Shared types, constants and helper functions for the Hill cipher block transform.
package hcbt_pkg;

  localparam int MAX_SIZE        = 6;
  localparam int LETTER_W        = 5;
  localparam int SIZE_W          = 3;
  localparam int ROW_W           = 30;
  localparam int IDX_W           = 3;
  localparam int ALPHABET        = 26;
  localparam int PAD_LETTER      = 23;
  localparam int SUM_W           = 12;
  localparam int RECIP           = 2521;   // ceil(2^16 / 26), exact for sums below 4096
  localparam int RECIP_SHIFT     = 16;
  localparam int PROD_W          = SUM_W + RECIP_SHIFT - 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_ZERO = 3'd1;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 3'd2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [SIZE_W-1:0]   size_t;

  typedef struct packed {
    letter_t [MAX_SIZE-1:0] letters;
    size_t                  size;
    logic                   last;
  } block_t;

  typedef struct packed {
    size_t                                block_size;
    letter_t [MAX_SIZE-1:0][MAX_SIZE-1:0] key;   // key[row][col], already reduced mod 26
  } cfg_t;

  function automatic letter_t reduce26(input logic [LETTER_W-1:0] v);
    letter_t r;
    r = (v >= LETTER_W'(ALPHABET)) ? v - LETTER_W'(ALPHABET) : v;
    return r;
  endfunction

  // Zero acts as one, anything above the matrix limit saturates.
  function automatic size_t eff_size(input size_t bs);
    size_t n;
    if (bs == '0) n = SIZE_W'(1);
    else if (bs > SIZE_W'(MAX_SIZE)) n = SIZE_W'(MAX_SIZE);
    else n = bs;
    return n;
  endfunction

endpackage

// ----- sv/hcbt_front.sv -----
// Front end: gathers letters into a block, pads short final blocks, hands blocks to the queue.
module hcbt_front
  import hcbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  letter_t letter_in,
  input  logic    message_end,
  input  size_t   block_size,
  input  logic    q_full,
  output logic    push,
  output block_t  push_data
);

  letter_t slots [MAX_SIZE];
  size_t   fill_count;

  size_t   n;
  size_t   pos;
  size_t   pos_inc;
  letter_t letter_r;
  logic    accept;
  logic    done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    n        = eff_size(block_size);
    pos      = (fill_count >= n) ? n - SIZE_W'(1) : fill_count;
    pos_inc  = pos + SIZE_W'(1);
    letter_r = reduce26(letter_in);
    done     = (pos_inc == n) || message_end;
    push     = accept && done;
    for (int j = 0; j < MAX_SIZE; j++) begin
      if (SIZE_W'(j) == pos) push_data.letters[j] = letter_r;
      else if (SIZE_W'(j) < pos) push_data.letters[j] = slots[j];
      else push_data.letters[j] = LETTER_W'(PAD_LETTER);
    end
    push_data.size = n;
    push_data.last = message_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= done ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[pos] <= letter_r;
    end
  end

endmodule

// ----- sv/hcbt_queue.sv -----
// Short block queue that decouples the front end from the back end.
module hcbt_queue
  import hcbt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  block_t push_data,
  input  logic   pop,
  output block_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  block_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/hcbt_back.sv -----
// Back end: a key-row dot product per cycle unless stalled; mod 26; output register.
module hcbt_back
  import hcbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  block_t  head,
  input  logic    q_empty,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output letter_t letter_out,
  output logic    block_last,
  output logic    message_last
);

  size_t             row;
  logic              b_valid;
  logic [SUM_W-1:0]  b_sum;
  logic              b_blast;
  logic              b_mlast;

  logic              c_ready;
  logic              b_ready;
  logic              issue;
  logic              row_last;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quo;
  logic [SUM_W-1:0]  rem;
  letter_t           letter_mod;

  assign c_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || c_ready;
  assign issue    = !q_empty && b_ready;
  assign row_last = (row == head.size - SIZE_W'(1));
  assign pop      = issue && row_last;

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_SIZE; j++) begin
      if (SIZE_W'(j) < head.size) begin
        sum = sum + SUM_W'(cfg.key[row][j]) * SUM_W'(head.letters[j]);
      end
    end
  end

  // sum mod 26 through a reciprocal multiply, with one correction step
  always_comb begin
    prod = PROD_W'(b_sum) * PROD_W'(RECIP);
    quo  = SUM_W'(prod[PROD_W-1:RECIP_SHIFT]);
    rem  = b_sum - quo * SUM_W'(ALPHABET);
    if (rem >= SUM_W'(ALPHABET)) rem = rem - SUM_W'(ALPHABET);
    letter_mod = rem[LETTER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        row     <= row_last ? '0 : row + SIZE_W'(1);
        b_valid <= 1'b1;
      end else if (c_ready) begin
        b_valid <= 1'b0;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_sum   <= sum;
      b_blast <= row_last;
      b_mlast <= row_last && head.last;
    end
    if (c_ready && b_valid) begin
      letter_out   <= letter_mod;
      block_last   <= b_blast;
      message_last <= b_mlast;
    end
  end

endmodule

// ----- sv/hill_cipher_block_transform_top.sv -----
// Top level of the Hill cipher block transform: configuration registers, front, queue, back.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  letter_in, message_end
//   output   out        out_valid/out_stall  letter_out, block_last, message_last
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front end takes one letter per cycle unless in_stall is high; the back end emits one
// letter per cycle when not stalled, one key-row dot product each (a 6-term multiply-add).
// The first result of a block goes through the queue entry, b_sum and the output register.
// in_stall is high while the block queue (QUEUE_DEPTH blocks) is full.
// Synchronous reset; no clearing pass, the letter slots are always written before use.
module hill_cipher_block_transform_top
  import hcbt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  letter_t          letter_in,
  input  logic             message_end,
  output logic             out_valid,
  input  logic             out_stall,
  output letter_t          letter_out,
  output logic             block_last,
  output logic             message_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  block_t push_data;
  logic   pop;
  block_t head;
  logic   q_full;
  logic   q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size <= BLOCK_SIZE_RST;
      cfg.key        <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BLOCK_SIZE) begin
        cfg.block_size <= cfg_data[SIZE_W-1:0];
      end
      for (int r = 0; r < MAX_SIZE; r++) begin
        if (cfg_index == REG_KEY_ROW_ZERO + IDX_W'(r)) begin
          for (int j = 0; j < MAX_SIZE; j++) begin
            cfg.key[r][j] <= reduce26(cfg_data[LETTER_W*j +: LETTER_W]);
          end
        end
      end
    end
  end

  hcbt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .letter_in   (letter_in),
    .message_end (message_end),
    .block_size  (cfg.block_size),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  hcbt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  hcbt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .letter_out   (letter_out),
    .block_last   (block_last),
    .message_last (message_last)
  );

endmodule

// ----- sv/hcbt_checker.sv -----
// Port-level checker for the Hill cipher block transform, bound to the top level.
`include "hill_cipher_block_transform_top_macros.svh"

module hcbt_checker
  import hcbt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input letter_t letter_out,
  input logic    block_last,
  input logic    message_last
);

  logic [LETTER_W+1:0] out_word;

  assign out_word = {letter_out, block_last, message_last};

  `HCBT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  `HCBT_ASSERT_NOW(a_letter_range, clk, rst, out_valid, letter_out < LETTER_W'(ALPHABET))
  `HCBT_ASSERT_NOW(a_msg_ends_block, clk, rst, out_valid && message_last, block_last)
  `HCBT_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind hill_cipher_block_transform_top hcbt_checker u_hcbt_checker (.*);
